// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/msbpk_pkg.sv
// ----------------------------------------------------------------------------
// msbpk_pkg
// Shared constants and controller/datapath interface types of the bit packer.
// ----------------------------------------------------------------------------
package msbpk_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int COUNT_BITS        = 6;
    localparam int MAX_WIDTH_DEFAULT = 32;
    // An item never completes more than five bytes: 5 * 8 - 7 bits at most
    localparam int ITEM_BIT_LIMIT    = 33;
    localparam int WORD_BITS         = 40;
    localparam int HELD_BITS         = 7;
    localparam int BYTE_CNT_BITS     = 3;

    typedef struct packed {
        logic load;
        logic emit;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic [BYTE_CNT_BITS-1:0] load_bytes;
    } dp_status_t;

endpackage

// File: sv/msbpk_datapath.sv
// ----------------------------------------------------------------------------
// msbpk_datapath
// Bit window, held-bit store and output byte register of the bit packer.
// ----------------------------------------------------------------------------
module msbpk_datapath
    import msbpk_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [COUNT_BITS-1:0] bit_count,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [7:0]            out_byte,
    output logic                  last_byte
);

    localparam int CountCap = (MAX_WIDTH < ITEM_BIT_LIMIT) ? MAX_WIDTH : ITEM_BIT_LIMIT;
    localparam logic [COUNT_BITS-1:0] CountLimit = COUNT_BITS'(CountCap);
    localparam logic [COUNT_BITS-1:0] WordSize   = COUNT_BITS'(WORD_BITS);

    logic [HELD_BITS-1:0]  pend_reg;     // held bits, earliest in the MSB, zero below
    logic [2:0]            held_reg;
    logic [WORD_BITS-1:0]  word_reg;
    logic [7:0]            out_byte_reg;
    logic                  last_byte_reg;

    logic [COUNT_BITS-1:0] count_sat;
    logic [VALUE_BITS-1:0] value_mask;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] shift_amt;
    logic [WORD_BITS-1:0]  word_next;

    always_comb
    begin
        count_sat  = (bit_count > CountLimit) ? CountLimit : bit_count;
        // Shifts of 32 or more clear the vector, leaving the mask all ones
        value_mask = ~({VALUE_BITS{1'b1}} << count_sat);
        total      = count_sat + COUNT_BITS'(held_reg);
        shift_amt  = WordSize - total;
        // Left-align the new bits right behind the held bits
        word_next  = {pend_reg, {(WORD_BITS-HELD_BITS){1'b0}}}
                   | ({{(WORD_BITS-VALUE_BITS){1'b0}}, value & value_mask} << shift_amt);
        status.load_bytes = total[COUNT_BITS-1:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            held_reg <= '0;
        end
        else if (cmd.load)
        begin
            held_reg <= total[2:0];
            if (status.load_bytes == '0)
            begin
                pend_reg <= word_next[WORD_BITS-1 -: HELD_BITS];
            end
        end
        else if (cmd.emit && cmd.last)
        begin
            pend_reg <= word_reg[WORD_BITS-9 -: HELD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= word_next;
        end
        else if (cmd.emit)
        begin
            out_byte_reg  <= word_reg[WORD_BITS-1 -: 8];
            last_byte_reg <= cmd.last;
            word_reg      <= word_reg << 8;
        end
    end

    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

// File: sv/msbpk_ctrl.sv
// ----------------------------------------------------------------------------
// msbpk_ctrl
// Sequencer: takes a request, then releases its bytes one per free output slot.
// ----------------------------------------------------------------------------
module msbpk_ctrl
    import msbpk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic {
        IDLE,
        EMIT
    } state_t;

    state_t                   state_reg;
    logic [BYTE_CNT_BITS-1:0] remain_reg;
    logic                     out_valid_reg;
    logic                     slot_free;

    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        cmd.load  = (state_reg == IDLE) && in_valid;
        cmd.emit  = (state_reg == EMIT) && slot_free;
        cmd.last  = (remain_reg == BYTE_CNT_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (cmd.load && (status.load_bytes != '0))
                    begin
                        remain_reg <= status.load_bytes;
                        state_reg  <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (cmd.emit)
                    begin
                        remain_reg <= remain_reg - BYTE_CNT_BITS'(1);
                        if (cmd.last)
                        begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg == EMIT);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// MSB-first bitstream writer: appends bit_count low bits of value, emits bytes.
// Flow: an accepted request is loaded into the bit window, then its bytes go
//   to the single output byte register one byte per cycle while it is free.
//   A request that completes no byte never stalls the request side; one that
//   completes n bytes (n up to 5) stalls it until its last byte is emitted.
// Reset: rst_n clears held bits, sequencer state and output valid at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_packer
    import msbpk_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [COUNT_BITS-1:0] bit_count,
    // byte channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last_byte
);

    // Controller and datapath talk only through these two bundles:
    // cmd carries load/emit/last strobes, status reports how many whole
    // bytes the incoming request completes together with the held bits.
    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: accept a request while idle, then hold the request side
    // and advance one byte into the output register whenever it is free.
    msbpk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: saturate the count, merge the new bits behind the held bits
    // in a 40-bit left-aligned window, and shift bytes off its top. Leftover
    // bits (fewer than eight) stay held for the next request.
    msbpk_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .bit_count (bit_count),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    // Never overwrite a byte that the receiver is still stalling on
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.emit && out_valid && out_stall,
        "byte emitted while output register is full and stalled")

    // A request that completes whole bytes must hold off the next request
    `ASSERT_NEXT(a_busy_after_load, clk, rst_n,
        in_valid && !in_stall && (status.load_bytes != '0), in_stall,
        "request side not stalled while bytes are pending")

    // Releasing the final byte frees the request side in the next cycle
    `ASSERT_NEXT(a_free_after_last, clk, rst_n, cmd.emit && cmd.last,
        !in_stall && out_valid && last_byte,
        "final byte did not mark the output or release the request side")

endmodule
